// ===== rtl/linear_probe_hash_table_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the linear probe hash table
// Shared same-cycle-implication and next-cycle-implication property forms.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPHT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");

// next-cycle implication, disabled during reset
`define LPHT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");

`endif

// ===== rtl/lpht_pkg.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash table package
// Request/response types, status and command codes, default sizes.
// ---------------------------------------------------------------------------
package lpht_pkg;

    // default sizes
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_VALUE_BITS  = 32;

    // configuration port
    localparam int       PADDR_W          = 3;
    localparam logic     REG_TABLE_SIZE   = 1'b0;
    localparam logic [8:0] TABLE_SIZE_RESET = 9'd256;

    // entry counter saturation
    localparam logic [8:0] COUNT_MAX = 9'h1FF;

    // commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // response status codes
    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_FOUND    = 2'd2;
    localparam logic [1:0] STATUS_MISSING  = 2'd3;

    typedef struct packed {
        logic        command;
        logic [31:0] hash_value;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [8:0]  entry_count;
    } rsp_t;

    // byte mask that keeps key bytes below len
    function automatic logic [63:0] key_mask(input logic [3:0] len);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[i*8 +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/linear_probe_hash_table_top.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing table with insert and lookup requests over one slot RAM.
// ---------------------------------------------------------------------------
// After reset the block sweeps the slot RAM once, one slot per cycle,
// and takes no request until that pass is done; the table_size register
// can be written meanwhile. A request then runs the bit-serial remainder
// that maps the hash to its home slot, then probes slots from there, at
// most the table size in use, one RAM read per cycle, until a slot settles
// it or every slot in use has been checked. A request with a bad key length
// skips both and goes straight to the report state. One request is in work
// at a time; the response sits in an output register, so the next request
// is taken while it waits.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = DEF_KEY_BYTES,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int SIZE_W   = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS = KEY_BYTES * 8;
    localparam logic [3:0]       MAX_LEN  = 4'(KEY_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic                  valid;
        logic [3:0]            len;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_row_t;

    localparam int ROW_W = $bits(slot_row_t);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_REPORT
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [8:0]            table_size_reg, table_size_next;
    logic [8:0]            count_reg, count_next;
    logic                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [3:0]            len_reg, len_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [IDX_W-1:0]      addr_reg, addr_next;
    logic [SIZE_W-1:0]     issued_reg, issued_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [31:0]           res_value_reg, res_value_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    slot_row_t             ram_wdata;
    slot_row_t             ram_rdata;
    logic                  rem_start;
    logic                  rem_done;
    logic [IDX_W-1:0]      rem_value;

    logic [SIZE_W-1:0]     size_sel;
    logic                  len_ok;
    logic [63:0]           key_masked;
    logic                  apb_wr;
    logic                  slot_hit;
    logic                  finish;
    logic [IDX_W-1:0]      addr_wrap;

    // size in use: zero counts as one, above the depth saturates
    always_comb
    begin
        if (table_size_reg == 9'd0)
        begin
            size_sel = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            size_sel = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            size_sel = SIZE_W'(table_size_reg);
        end
    end

    assign len_ok     = (req.key_length != 4'd0) && (req.key_length <= MAX_LEN);
    assign key_masked = req.key_bytes & key_mask(req.key_length);
    assign apb_wr     = psel && penable && pwrite && pready;

    // probe compare against the slot read last cycle
    assign slot_hit = ram_rdata.valid && (ram_rdata.len == len_reg) &&
                      (ram_rdata.key == key_reg);

    // next probe address with wraparound at the size in use
    assign addr_wrap = ((SIZE_W'(addr_reg) + SIZE_W'(1)) == size_reg) ?
                       '0 : (addr_reg + IDX_W'(1));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        table_size_next = table_size_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        val_next        = val_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        issued_next     = issued_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = '0;
        rem_start       = 1'b0;
        finish          = 1'b0;

        if (apb_wr && (paddr[2] == REG_TABLE_SIZE))
        begin
            table_size_next = pwdata[8:0];
        end

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = req.command;
                    key_next        = KEY_BITS'(key_masked);
                    len_next        = req.key_length;
                    val_next        = VALUE_BITS'(req.entry_value);
                    size_next       = size_sel;
                    res_value_next  = '0;
                    res_status_next = (req.command == CMD_INSERT) ?
                                      STATUS_REJECTED : STATUS_MISSING;
                    if (len_ok)
                    begin
                        rem_start  = 1'b1;
                        state_next = S_HASH;
                    end
                    else
                    begin
                        state_next = S_REPORT;
                    end
                end
            end

            S_HASH:
            begin
                if (rem_done)
                begin
                    addr_next       = rem_value;
                    issued_next     = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // check the slot whose data came back this cycle
                if (pend_valid_reg)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (!ram_rdata.valid)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.valid = 1'b1;
                            ram_wdata.len   = len_reg;
                            ram_wdata.key   = key_reg;
                            ram_wdata.value = val_reg;
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + 9'd1;
                            end
                            res_status_next = STATUS_INSERTED;
                            finish          = 1'b1;
                        end
                        else if (slot_hit)
                        begin
                            finish = 1'b1;
                        end
                    end
                    else if (slot_hit)
                    begin
                        res_status_next = STATUS_FOUND;
                        res_value_next  = 32'(ram_rdata.value);
                        finish          = 1'b1;
                    end
                end

                // issue the next read, or stop on a result or when every slot is checked
                if (finish)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_REPORT;
                end
                else if (issued_reg != size_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = addr_reg;
                    addr_next       = addr_wrap;
                    issued_next     = issued_reg + SIZE_W'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        state_next = S_REPORT;
                    end
                end
            end

            S_REPORT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = res_status_reg;
                    rsp_next.found_value = res_value_reg;
                    rsp_next.entry_count = count_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            table_size_reg <= TABLE_SIZE_RESET;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            table_size_reg <= table_size_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    // request payload and probe datapath
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        val_reg        <= val_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        issued_reg     <= issued_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
    end

    lpht_rem_unit #(
        .DIV_W (SIZE_W),
        .OUT_W (IDX_W)
    ) u_rem_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (req.hash_value),
        .divisor   (size_sel),
        .done      (rem_done),
        .remainder (rem_value)
    );

    lpht_slot_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ROW_W  (ROW_W),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TABLE_SIZE) ? {23'd0, table_size_reg} : 32'd0;

endmodule

// ===== rtl/lpht_rem_unit.sv =====
// ---------------------------------------------------------------------------
// Remainder unit
// Restoring remainder of a 32-bit hash by the table size, one bit per cycle.
// ---------------------------------------------------------------------------
module lpht_rem_unit
    import lpht_pkg::*;
#(
    parameter int DIV_W = 9,
    parameter int OUT_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [OUT_W-1:0] remainder
);

    logic [31:0]      dividend_reg, dividend_next;
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial         = {rem_reg, dividend_reg[31]};
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (start)
        begin
            dividend_next = dividend;
            divisor_next  = divisor;
            rem_next      = '0;
            cnt_next      = 5'd31;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            dividend_next = {dividend_reg[30:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = OUT_W'(rem_reg);

endmodule

// ===== rtl/lpht_slot_ram.sv =====
// ---------------------------------------------------------------------------
// Slot memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lpht_slot_ram
    import lpht_pkg::*;
#(
    parameter int DEPTH  = DEF_TABLE_DEPTH,
    parameter int ROW_W  = 101,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lpht_checker.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash table port checker
// Port-level properties of the request and response channels.
// ---------------------------------------------------------------------------
`include "linear_probe_hash_table_top_macros.svh"

module lpht_checker
    import lpht_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // a stalled response holds
    `LPHT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // one request in work at a time
    `LPHT_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // a value comes back only with a hit
    `LPHT_ASSERT_IMP(a_value_on_hit, clk, rst_n, rsp_valid && (rsp.status != STATUS_FOUND), rsp.found_value == 32'd0)

    // a successful insert leaves at least one entry
    `LPHT_ASSERT_IMP(a_insert_counts, clk, rst_n, rsp_valid && (rsp.status == STATUS_INSERTED), rsp.entry_count != 9'd0)

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);
